[rtl/udc_pkg.sv]
package udc_pkg;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam int unsigned FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
    } t_push;

    typedef struct packed {
        logic       hit;
        logic [7:0] out_byte;
    } t_map;

    function automatic t_map map_code(input logic [10:0] cp);
        t_map        m;
        logic [15:0] c;
        logic [10:0] d;
        c          = {5'd0, cp};
        d          = '0;
        m.hit      = 1'b1;
        m.out_byte = 8'h00;
        if (cp >= 11'h410 && cp <= 11'h44F) begin
            d          = cp - 11'h350;
            m.out_byte = d[7:0];
        end else if (cp >= 11'h080 && cp <= 11'h0FF) begin
            m.out_byte = cp[7:0];
        end else if (cp >= 11'h402 && cp <= 11'h403) begin
            d          = cp - 11'h382;
            m.out_byte = d[7:0];
        end else begin
            unique case (c)
                16'h201A: m.out_byte = 8'h82;
                16'h0453: m.out_byte = 8'h83;
                16'h201E: m.out_byte = 8'h84;
                16'h2026: m.out_byte = 8'h85;
                16'h2020: m.out_byte = 8'h86;
                16'h2021: m.out_byte = 8'h87;
                16'h20AC: m.out_byte = 8'h88;
                16'h2030: m.out_byte = 8'h89;
                16'h0409: m.out_byte = 8'h8A;
                16'h2039: m.out_byte = 8'h8B;
                16'h040A: m.out_byte = 8'h8C;
                16'h040C: m.out_byte = 8'h8D;
                16'h040B: m.out_byte = 8'h8E;
                16'h040F: m.out_byte = 8'h8F;
                16'h0452: m.out_byte = 8'h90;
                16'h2018: m.out_byte = 8'h91;
                16'h2019: m.out_byte = 8'h92;
                16'h201C: m.out_byte = 8'h93;
                16'h201D: m.out_byte = 8'h94;
                16'h2022: m.out_byte = 8'h95;
                16'h2013: m.out_byte = 8'h96;
                16'h2014: m.out_byte = 8'h97;
                16'h2122: m.out_byte = 8'h99;
                16'h0459: m.out_byte = 8'h9A;
                16'h203A: m.out_byte = 8'h9B;
                16'h045A: m.out_byte = 8'h9C;
                16'h045C: m.out_byte = 8'h9D;
                16'h045B: m.out_byte = 8'h9E;
                16'h045F: m.out_byte = 8'h9F;
                16'h00A0: m.out_byte = 8'hA0;
                16'h040E: m.out_byte = 8'hA1;
                16'h045E: m.out_byte = 8'hA2;
                16'h0408: m.out_byte = 8'hA3;
                16'h00A4: m.out_byte = 8'hA4;
                16'h0490: m.out_byte = 8'hA5;
                16'h00A6: m.out_byte = 8'hA6;
                16'h00A7: m.out_byte = 8'hA7;
                16'h0401: m.out_byte = 8'hA8;
                16'h00A9: m.out_byte = 8'hA9;
                16'h0404: m.out_byte = 8'hAA;
                16'h00AB: m.out_byte = 8'hAB;
                16'h00AC: m.out_byte = 8'hAC;
                16'h00AD: m.out_byte = 8'hAD;
                16'h00AE: m.out_byte = 8'hAE;
                16'h0407: m.out_byte = 8'hAF;
                16'h00B0: m.out_byte = 8'hB0;
                16'h00B1: m.out_byte = 8'hB1;
                16'h0406: m.out_byte = 8'hB2;
                16'h0456: m.out_byte = 8'hB3;
                16'h0491: m.out_byte = 8'hB4;
                16'h00B5: m.out_byte = 8'hB5;
                16'h00B6: m.out_byte = 8'hB6;
                16'h00B7: m.out_byte = 8'hB7;
                16'h0451: m.out_byte = 8'hB8;
                16'h2116: m.out_byte = 8'hB9;
                16'h0454: m.out_byte = 8'hBA;
                16'h00BB: m.out_byte = 8'hBB;
                16'h0458: m.out_byte = 8'hBC;
                16'h0405: m.out_byte = 8'hBD;
                16'h0455: m.out_byte = 8'hBE;
                16'h0457: m.out_byte = 8'hBF;
                default:  m.hit      = 1'b0;
            endcase
        end
        return m;
    endfunction

endpackage

[rtl/udc_decode.sv]
module udc_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_in_byte,
    input  logic                i_room,
    output udc_pkg::t_push      o_push
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic [4:0]   r_lead_bits;
    logic         r_lead_pending;
    logic         r_rejected;
    logic [4:0]   n_lead_bits;
    logic         n_lead_pending;
    logic         n_rejected;
    logic         fire;
    logic         accept;
    udc_pkg::t_map m;
    udc_pkg::t_push p;

    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || fire;
    assign accept  = i_valid && o_ready;
    assign m       = udc_pkg::map_code({r_lead_bits, r_in_byte[5:0]});

    always_comb begin
        p              = '0;
        n_lead_bits    = r_lead_bits;
        n_lead_pending = r_lead_pending;
        n_rejected     = r_rejected;
        if (r_rejected) begin
            if (r_in_byte == 8'h00) begin
                n_rejected = 1'b0;
            end
        end else if (r_lead_pending) begin
            n_lead_pending = 1'b0;
            n_lead_bits    = '0;
            if (!m.hit) begin
                p.count     = 2'd1;
                p.res0.kind = udc_pkg::KIND_REJECT;
                p.res0.last = 1'b1;
                n_rejected  = (r_in_byte != 8'h00);
            end else if (r_in_byte == 8'h00) begin
                p.count         = 2'd2;
                p.res0.out_byte = m.out_byte;
                p.res0.kind     = udc_pkg::KIND_CHAR;
                p.res1.kind     = udc_pkg::KIND_END;
                p.res1.last     = 1'b1;
            end else begin
                p.count         = 2'd1;
                p.res0.out_byte = m.out_byte;
                p.res0.kind     = udc_pkg::KIND_CHAR;
                p.res0.last     = 1'b1;
            end
        end else if (r_in_byte == 8'h00) begin
            p.count     = 2'd1;
            p.res0.kind = udc_pkg::KIND_END;
            p.res0.last = 1'b1;
        end else if (!r_in_byte[7]) begin
            p.count         = 2'd1;
            p.res0.out_byte = r_in_byte;
            p.res0.kind     = udc_pkg::KIND_CHAR;
            p.res0.last     = 1'b1;
        end else if (!r_in_byte[5]) begin
            n_lead_bits    = r_in_byte[4:0];
            n_lead_pending = 1'b1;
        end else begin
            p.count     = 2'd1;
            p.res0.kind = udc_pkg::KIND_REJECT;
            p.res0.last = 1'b1;
            n_rejected  = 1'b1;
        end
    end

    always_comb begin
        o_push = p;
        if (!fire) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_lead_bits    <= '0;
            r_lead_pending <= 1'b0;
            r_rejected     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_lead_bits    <= n_lead_bits;
                r_lead_pending <= n_lead_pending;
                r_rejected     <= n_rejected;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
        end
    end

endmodule

[rtl/udc_res_fifo.sv]
module udc_res_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  udc_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output udc_pkg::t_res  o_res
);

    localparam int unsigned AW = $clog2(udc_pkg::FIFO_DEPTH);
    localparam int unsigned CW = $clog2(udc_pkg::FIFO_DEPTH + 1);

    udc_pkg::t_res r_mem [udc_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] wr1;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_cnt <= CW'(udc_pkg::FIFO_DEPTH - 2));
    assign wr1     = r_wr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + AW'(i_push.count);
            r_cnt <= r_cnt + CW'(i_push.count) - CW'(pop);
            if (pop) begin
                r_rd <= r_rd + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr1] <= i_push.res1;
        end
    end

endmodule

[rtl/utf8_to_cp1251_decoder_top.sv]
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------
// input    | i_valid / o_ready  | i_in_byte
// output   | o_valid / i_ready  | o_out_byte, o_kind, o_last
//
// One word enters per cycle while the queue has room; it is registered, then queued.
// A lead before the terminator yields two words, which the result queue absorbs.
// Input stalls only when the four-entry result queue lacks room for two words.
// Synchronous active-low reset clears the lead, reject state and the queue.
module utf8_to_cp1251_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    udc_pkg::t_push push;
    udc_pkg::t_res  res;
    logic           room;

    udc_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_room    (room),
        .o_push    (push)
    );

    udc_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_out_byte = res.out_byte;
    assign o_kind     = res.kind;
    assign o_last     = res.last;

    a_nonchar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != udc_pkg::KIND_CHAR |-> o_out_byte == 8'h00)
        else $error("non-character word carries a byte");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == udc_pkg::KIND_REJECT |-> o_last)
        else $error("reject word not last");

    a_char_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == udc_pkg::KIND_CHAR && !o_last && i_ready
        |=> o_valid && o_kind == udc_pkg::KIND_END)
        else $error("end word missing after final character");

endmodule

[test/utf8_cp1251_checker.sv]
module utf8_cp1251_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic [1:0] i_out_kind,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_words_pending,
    output int         o_bytes_used,
    output int         o_words_checked,
    output int         o_rejects
);

    udc_pkg::t_res expected_words[$];
    logic [4:0]    lead_hi;
    logic          lead_wait;
    logic          dropping;

    initial begin
        o_fail_count    = 0;
        o_words_pending = 0;
        o_bytes_used    = 0;
        o_words_checked = 0;
        o_rejects       = 0;
        lead_hi         = '0;
        lead_wait       = 1'b0;
        dropping        = 1'b0;
    end

    function automatic logic cp1251_of(input logic [10:0] cp, output logic [7:0] ch);
        logic        hit;
        logic [10:0] d;
        hit = 1'b1;
        ch  = 8'h00;
        if (cp >= 11'h410 && cp <= 11'h44F) begin
            d  = cp - 11'h350;
            ch = d[7:0];
        end else if (cp >= 11'h080 && cp <= 11'h0FF) begin
            ch = cp[7:0];
        end else if (cp >= 11'h402 && cp <= 11'h403) begin
            d  = cp - 11'h382;
            ch = d[7:0];
        end else begin
            case (cp)
                11'h453: ch = 8'h83;
                11'h409: ch = 8'h8A;
                11'h40A: ch = 8'h8C;
                11'h40C: ch = 8'h8D;
                11'h40B: ch = 8'h8E;
                11'h40F: ch = 8'h8F;
                11'h452: ch = 8'h90;
                11'h459: ch = 8'h9A;
                11'h45A: ch = 8'h9C;
                11'h45C: ch = 8'h9D;
                11'h45B: ch = 8'h9E;
                11'h45F: ch = 8'h9F;
                11'h40E: ch = 8'hA1;
                11'h45E: ch = 8'hA2;
                11'h408: ch = 8'hA3;
                11'h490: ch = 8'hA5;
                11'h401: ch = 8'hA8;
                11'h404: ch = 8'hAA;
                11'h407: ch = 8'hAF;
                11'h406: ch = 8'hB2;
                11'h456: ch = 8'hB3;
                11'h491: ch = 8'hB4;
                11'h451: ch = 8'hB8;
                11'h454: ch = 8'hBA;
                11'h458: ch = 8'hBC;
                11'h405: ch = 8'hBD;
                11'h455: ch = 8'hBE;
                11'h457: ch = 8'hBF;
                default: hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

    function automatic udc_pkg::t_res make_word(input logic [7:0] ch, input logic [1:0] kind,
                                                input logic last);
        udc_pkg::t_res w;
        w.out_byte = ch;
        w.kind     = kind;
        w.last     = last;
        return w;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [10:0] cp;
        logic [7:0]  ch;
        logic        hit;
        if (dropping) begin
            if (b == 8'h00) begin
                dropping = 1'b0;
            end
        end else begin
            o_bytes_used++;
            if (lead_wait) begin
                cp        = {lead_hi, b[5:0]};
                hit       = cp1251_of(cp, ch);
                lead_wait = 1'b0;
                lead_hi   = '0;
                if (!hit) begin
                    expected_words.push_back(make_word(8'h00, udc_pkg::KIND_REJECT, 1'b1));
                    dropping = (b != 8'h00);
                end else if (b == 8'h00) begin
                    expected_words.push_back(make_word(ch, udc_pkg::KIND_CHAR, 1'b0));
                    expected_words.push_back(make_word(8'h00, udc_pkg::KIND_END, 1'b1));
                end else begin
                    expected_words.push_back(make_word(ch, udc_pkg::KIND_CHAR, 1'b1));
                end
            end else if (b == 8'h00) begin
                expected_words.push_back(make_word(8'h00, udc_pkg::KIND_END, 1'b1));
            end else if (!b[7]) begin
                expected_words.push_back(make_word(b, udc_pkg::KIND_CHAR, 1'b1));
            end else if (!b[5]) begin
                lead_hi   = b[4:0];
                lead_wait = 1'b1;
            end else begin
                dropping = 1'b1;
                expected_words.push_back(make_word(8'h00, udc_pkg::KIND_REJECT, 1'b1));
            end
        end
    endtask

    task automatic check_word;
        udc_pkg::t_res got;
        udc_pkg::t_res want;
        got = make_word(i_out_byte, i_out_kind, i_out_last);
        o_words_checked++;
        if (got.kind == udc_pkg::KIND_REJECT) begin
            o_rejects++;
        end
        if (expected_words.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("unexpected word: byte %02h kind %0d last %0b",
                         got.out_byte, got.kind, got.last);
            end
        end else begin
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.last !== want.last) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display({"mismatch: expected byte %02h kind %0d last %0b, ",
                              "got byte %02h kind %0d last %0b"},
                             want.out_byte, want.kind, want.last,
                             got.out_byte, got.kind, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            lead_hi   = '0;
            lead_wait = 1'b0;
            dropping  = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_word();
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_byte);
            end
        end
        o_words_pending = expected_words.size();
    end

endmodule

[test/utf8_to_cp1251_decoder_top_tb.sv]
module utf8_to_cp1251_decoder_top_tb;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic       o_last;

    int fail_count;
    int words_pending;
    int bytes_used;
    int words_checked;
    int rejects;
    int bytes_sent   = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;

    logic [7:0] opening_bytes [27] = '{
        8'h00,
        8'h01, 8'h7F,
        8'hD0, 8'h90, 8'hD1, 8'h8F, 8'hC2, 8'h80, 8'hD0, 8'h82,
        8'hD2, 8'h90, 8'h90, 8'h81, 8'hD0, 8'h10,
        8'h00,
        8'hC2, 8'h00,
        8'hC0, 8'h80, 8'hFF, 8'h00,
        8'hE2, 8'h00,
        8'hD0
    };

    utf8_to_cp1251_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    utf8_cp1251_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_byte       (i_in_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_out_byte      (o_out_byte),
        .i_out_kind      (o_kind),
        .i_out_last      (o_last),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending),
        .o_bytes_used    (bytes_used),
        .o_words_checked (words_checked),
        .o_rejects       (rejects)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_char;
        int          r;
        logic [10:0] cp;
        logic [7:0]  lead;
        logic [7:0]  cont;
        logic [1:0]  top2;
        r = $urandom_range(99);
        if (r < 35) begin
            send_byte(8'($urandom_range(1, 127)));
        end else begin
            if (r < 60) begin
                cp = 11'h410 + 11'($urandom_range(63));
            end else if (r < 70) begin
                cp = 11'h080 + 11'($urandom_range(127));
            end else if (r < 74) begin
                cp = 11'h402 + 11'($urandom_range(1));
            end else if (r < 78) begin
                cp = 11'h490 + 11'($urandom_range(1));
            end else if (r < 91) begin
                cp = 11'h400 + 11'($urandom_range(11'h9F));
            end else begin
                cp = 11'($urandom_range(11'h7FF));
            end
            lead = {3'b110, cp[10:6]};
            if ($urandom_range(9) == 0) begin
                lead[6] = 1'b0;
            end
            cont = {2'b10, cp[5:0]};
            if ($urandom_range(3) == 0) begin
                top2       = 2'($urandom_range(3));
                cont[7:6]  = top2;
            end
            send_byte(lead);
            send_byte(cont);
        end
    endtask

    task automatic send_string;
        int         r;
        int         n;
        logic [4:0] hi;
        r = $urandom_range(99);
        if (r < 15) begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom_range(255)));
        end else begin
            n = $urandom_range(0, 10);
            repeat (n) send_char();
            if (r < 30) begin
                hi = 5'($urandom_range(31));
                send_byte({3'b110, hi});
            end
        end
        send_byte(8'h00);
    endtask

    initial begin
        int goal;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_byte <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_bytes[k]) begin
            send_byte(opening_bytes[k]);
        end
        send_byte(8'h00);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            goal = bytes_used + 250;
            while (bytes_used < goal) begin
                send_string();
            end
        end

        i_valid <= 1'b0;
        wait (words_pending == 0);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d bytes (%0d decoded, rest dropped) across four idle/stall phases.",
                 bytes_sent, bytes_used);
        $display("Checked %0d result words, %0d of them string rejections.",
                 words_checked, rejects);
        if (fail_count == 0) begin
            $display("utf8_to_cp1251_decoder_top test passed");
        end else begin
            $display("utf8_to_cp1251_decoder_top test failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("utf8_to_cp1251_decoder_top test failed");
        $finish;
    end

endmodule
